@@ src/keypad_scan_debounce_repeat_fifo_assert.svh @@
// Assertion macros shared by the keypad scanner checker.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef KEYPAD_SCAN_DEBOUNCE_REPEAT_FIFO_ASSERT_SVH
`define KEYPAD_SCAN_DEBOUNCE_REPEAT_FIFO_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define KSDRF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define KSDRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/ksdrf_pkg.sv @@
// Package of the keypad scanner: sizes, codes, types and decode functions.
// Used by the scan, buffer and top-level modules; depends on nothing.
package ksdrf_pkg;

  localparam int ROWS       = 2;
  localparam int COLS       = 2;
  localparam int FIFO_DEPTH = 16;

  localparam int MATRIX_W  = 4;
  localparam int SHIFT_W   = 2;
  localparam int CODE_W    = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int ROW_SEL_W = $clog2(ROWS + 1);
  localparam int PTR_W     = $clog2(FIFO_DEPTH);
  localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [CODE_W-1:0] NO_CODE = 8'hFF;
  localparam logic              OP_SCAN = 1'b0;
  localparam logic              OP_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_START_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_ONE_OFFSET   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_TWO_OFFSET   = 2'd3;

  typedef enum logic [1:0] {
    PH_UP,
    PH_DEBOUNCE,
    PH_START_DLY,
    PH_REPEAT
  } ksdrf_phase_e;

  typedef struct packed {
    logic [CFG_W-1:0] repeat_start_delay;
    logic [CFG_W-1:0] repeat_interval;
    logic [CFG_W-1:0] shift_one_offset;
    logic [CFG_W-1:0] shift_two_offset;
  } ksdrf_cfg_t;

  typedef struct packed {
    logic              push;
    logic [CODE_W-1:0] code;
  } ksdrf_push_t;

  typedef struct packed {
    logic [CODE_W-1:0] key_code;
    logic              code_valid;
    logic [CNT_W-1:0]  codes_waiting;
  } ksdrf_rd_t;

  typedef struct packed {
    logic [ROW_SEL_W-1:0] row_sel;
    logic [CODE_W-1:0]    base;
  } ksdrf_dec_t;

  // Columns seen while one row, or all rows when sel equals ROWS, are driven.
  function automatic logic [COLS-1:0] active_cols(logic [MATRIX_W-1:0] m,
                                                  logic [ROW_SEL_W-1:0] sel);
    logic [COLS-1:0] mask;
    mask = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (sel == ROW_SEL_W'(ROWS) || sel == ROW_SEL_W'(r)) begin
        mask = mask | m[r*COLS +: COLS];
      end
    end
    return mask;
  endfunction

  // First active row, lowest active column in it, before shift offsets.
  function automatic ksdrf_dec_t decode(logic [MATRIX_W-1:0] m);
    ksdrf_dec_t      res;
    logic            found;
    int              row;
    int              col;
    logic [COLS-1:0] cols;
    found       = 1'b0;
    row         = ROWS;
    res.row_sel = ROW_SEL_W'(ROWS - 1);
    for (int r = 0; r < ROWS; r++) begin
      if (!found && (|m[r*COLS +: COLS])) begin
        found       = 1'b1;
        row         = r;
        res.row_sel = ROW_SEL_W'(r);
      end
    end
    cols = active_cols(m, res.row_sel);
    col  = COLS;
    for (int c = COLS - 1; c >= 0; c--) begin
      if (cols[c]) begin
        col = c;
      end
    end
    res.base = CODE_W'(col) + CODE_W'(row * COLS);
    return res;
  endfunction

endpackage

@@ src/ksdrf_scan.sv @@
// Scan state machine: up, debounce, start delay and repeat, with key decode.
// Depends on ksdrf_pkg.
module ksdrf_scan (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               scan_i,
  input  logic [ksdrf_pkg::MATRIX_W-1:0]     matrix_i,
  input  logic [ksdrf_pkg::SHIFT_W-1:0]      shift_i,
  input  ksdrf_pkg::ksdrf_cfg_t              cfg_i,
  output ksdrf_pkg::ksdrf_push_t             push_o
);

  ksdrf_pkg::ksdrf_phase_e                 phase_q, phase_d;
  logic [ksdrf_pkg::ROW_SEL_W-1:0]         row_sel_q, row_sel_d;
  logic [ksdrf_pkg::CFG_W-1:0]             start_cnt_q, start_cnt_d;
  logic [ksdrf_pkg::CFG_W-1:0]             rep_cnt_q, rep_cnt_d;
  logic                                    down;
  logic                                    emit;
  ksdrf_pkg::ksdrf_dec_t                   dec;
  logic [ksdrf_pkg::CODE_W-1:0]            offset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ksdrf_pkg::PH_UP;
      row_sel_q   <= ksdrf_pkg::ROW_SEL_W'(ksdrf_pkg::ROWS);
      start_cnt_q <= '0;
      rep_cnt_q   <= '0;
    end else begin
      phase_q     <= phase_d;
      row_sel_q   <= row_sel_d;
      start_cnt_q <= start_cnt_d;
      rep_cnt_q   <= rep_cnt_d;
    end
  end

  always_comb begin
    down   = |ksdrf_pkg::active_cols(matrix_i, row_sel_q);
    dec    = ksdrf_pkg::decode(matrix_i);
    offset = (shift_i[0] ? cfg_i.shift_one_offset : '0)
           + (shift_i[1] ? cfg_i.shift_two_offset : '0);
    phase_d     = phase_q;
    row_sel_d   = row_sel_q;
    start_cnt_d = start_cnt_q;
    rep_cnt_d   = rep_cnt_q;
    emit        = 1'b0;
    if (scan_i) begin
      case (phase_q)
        ksdrf_pkg::PH_UP: begin
          if (down) begin
            phase_d = ksdrf_pkg::PH_DEBOUNCE;
          end
        end
        ksdrf_pkg::PH_DEBOUNCE: begin
          if (down) begin
            emit        = 1'b1;
            start_cnt_d = cfg_i.repeat_start_delay;
            phase_d     = ksdrf_pkg::PH_START_DLY;
          end else begin
            row_sel_d = ksdrf_pkg::ROW_SEL_W'(ksdrf_pkg::ROWS);
            phase_d   = ksdrf_pkg::PH_UP;
          end
        end
        ksdrf_pkg::PH_START_DLY: begin
          if (!down) begin
            phase_d = ksdrf_pkg::PH_DEBOUNCE;
          end else if (start_cnt_q != '0) begin
            start_cnt_d = start_cnt_q - 1'b1;
            if (start_cnt_q == ksdrf_pkg::CFG_W'(1)) begin
              emit      = 1'b1;
              rep_cnt_d = cfg_i.repeat_interval;
              phase_d   = ksdrf_pkg::PH_REPEAT;
            end
          end
        end
        ksdrf_pkg::PH_REPEAT: begin
          if (!down) begin
            phase_d = ksdrf_pkg::PH_DEBOUNCE;
          end else if (rep_cnt_q != '0) begin
            rep_cnt_d = rep_cnt_q - 1'b1;
            if (rep_cnt_q == ksdrf_pkg::CFG_W'(1)) begin
              emit      = 1'b1;
              rep_cnt_d = cfg_i.repeat_interval;
            end
          end
        end
        default: begin
          phase_d = ksdrf_pkg::PH_UP;
        end
      endcase
      if (emit) begin
        row_sel_d = dec.row_sel;
      end
    end
    push_o.push = emit;
    push_o.code = dec.base + offset;
  end

endmodule

@@ src/ksdrf_fifo.sv @@
// Key-code buffer: register store with write and read pointers and a fill count.
// Depends on ksdrf_pkg.
module ksdrf_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ksdrf_pkg::ksdrf_push_t push_i,
  input  logic                   pop_i,
  output ksdrf_pkg::ksdrf_rd_t   rd_o
);

  logic [ksdrf_pkg::CODE_W-1:0] store_q [ksdrf_pkg::FIFO_DEPTH];
  logic [ksdrf_pkg::PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [ksdrf_pkg::PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [ksdrf_pkg::CNT_W-1:0]  count_q, count_d;
  logic                         do_push;
  logic                         do_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_i.code;
    end
  end

  always_comb begin
    do_push  = push_i.push && (count_q != ksdrf_pkg::CNT_W'(ksdrf_pkg::FIFO_DEPTH));
    do_pop   = pop_i && (count_q != '0);
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == ksdrf_pkg::PTR_W'(ksdrf_pkg::FIFO_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
      count_d  = count_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == ksdrf_pkg::PTR_W'(ksdrf_pkg::FIFO_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
      count_d  = count_q - 1'b1;
    end
    rd_o.key_code      = do_pop ? store_q[rd_ptr_q] : ksdrf_pkg::NO_CODE;
    rd_o.code_valid    = do_pop;
    rd_o.codes_waiting = count_d;
  end

endmodule

@@ src/keypad_scan_debounce_repeat_fifo.sv @@
// Top level of the keypad scanner: input register, scan machine, code buffer,
// configuration registers and output register. Depends on ksdrf_pkg.
// An accepted item passes the input register and then the output register before its result is presented.
// Throughput: one item per cycle; with both registers full the input waits on the receiver.
// Reset clears the scan state, pointers, count and configuration to defaults.
// Buffer entries are not cleared; an entry is only read after it was written.
module keypad_scan_debounce_repeat_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Bits from lowest: pressed_matrix[3:0], shift_keys[5:4], zero padding.
  input  logic [7:0]                      s_axis_tdata,
  // Bits from lowest: op.
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Bits from lowest: key_code[7:0], codes_waiting[12:8], zero padding.
  output logic [15:0]                     m_axis_tdata,
  // Bits from lowest: code_valid.
  output logic                            m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ksdrf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ksdrf_pkg::CFG_W-1:0]     cfg_data_i
);

  logic                               in_valid_q;
  logic                               in_op_q;
  logic [ksdrf_pkg::MATRIX_W-1:0]     in_matrix_q;
  logic [ksdrf_pkg::SHIFT_W-1:0]      in_shift_q;
  logic                               out_valid_q;
  ksdrf_pkg::ksdrf_rd_t               out_q;
  ksdrf_pkg::ksdrf_cfg_t              cfg_q;
  logic                               advance;
  logic                               exec;
  ksdrf_pkg::ksdrf_push_t             push;
  ksdrf_pkg::ksdrf_rd_t               rd;

  assign advance       = !out_valid_q || m_axis_tready;
  assign exec          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_q.repeat_start_delay <= 8'd50;
      cfg_q.repeat_interval    <= 8'd10;
      cfg_q.shift_one_offset   <= 8'd4;
      cfg_q.shift_two_offset   <= 8'd8;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          ksdrf_pkg::CFG_REPEAT_START_DELAY: cfg_q.repeat_start_delay <= cfg_data_i;
          ksdrf_pkg::CFG_REPEAT_INTERVAL:    cfg_q.repeat_interval    <= cfg_data_i;
          ksdrf_pkg::CFG_SHIFT_ONE_OFFSET:   cfg_q.shift_one_offset   <= cfg_data_i;
          ksdrf_pkg::CFG_SHIFT_TWO_OFFSET:   cfg_q.shift_two_offset   <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q     <= s_axis_tuser;
      in_matrix_q <= s_axis_tdata[ksdrf_pkg::MATRIX_W-1:0];
      in_shift_q  <= s_axis_tdata[ksdrf_pkg::MATRIX_W +: ksdrf_pkg::SHIFT_W];
    end
    if (exec) begin
      out_q <= rd;
    end
  end

  ksdrf_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .scan_i   (exec && (in_op_q == ksdrf_pkg::OP_SCAN)),
    .matrix_i (in_matrix_q),
    .shift_i  (in_shift_q),
    .cfg_i    (cfg_q),
    .push_o   (push)
  );

  ksdrf_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (exec && (in_op_q == ksdrf_pkg::OP_READ)),
    .rd_o   (rd)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.codes_waiting, out_q.key_code};
  assign m_axis_tuser  = out_q.code_valid;

endmodule

@@ src/ksdrf_checker.sv @@
// Port-level checker for the keypad scanner, bound to the top level.
// Depends on the assertion macro header.
`include "keypad_scan_debounce_repeat_fifo_assert.svh"

module ksdrf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  `KSDRF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `KSDRF_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `KSDRF_ASSERT_NOW(a_empty_code, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[7:0] == 8'hFF)
  `KSDRF_ASSERT_NOW(a_count_range, m_axis_tvalid, m_axis_tdata[12:8] <= 5'd16)

endmodule

bind keypad_scan_debounce_repeat_fifo ksdrf_checker u_ksdrf_checker (.*);
